### design/gtar_pkg.sv
`default_nettype none
package gtar_pkg;

  // Width of the attack_len field as it arrives on the input channel.
  localparam int ATTACK_LEN_W = 20;

  // The reciprocal is Q0.32 plus one integer bit, so a one-sample attack gives exactly 1.0.
  localparam int RECIP_BITS = 33;

  // Operation codes of the shared adder.
  typedef logic alu_op_t;
  localparam alu_op_t ALU_ADD = 1'b0;
  localparam alu_op_t ALU_SUB = 1'b1;

endpackage
`default_nettype wire

### design/gtar_addsub.sv
`default_nettype none
module gtar_addsub import gtar_pkg::*; #(
  parameter int W = 53
) (
  input  wire alu_op_t      op,
  input  wire logic [W-1:0] a,
  input  wire logic [W-1:0] b,
  output logic      [W-1:0] result
);

  logic [W-1:0] b_eff;
  logic         sub;

  assign sub    = (op == ALU_SUB);
  assign b_eff  = b ^ {W{sub}};
  assign result = a + b_eff + W'(sub);

endmodule
`default_nettype wire

### design/gate_to_attack_ramp.sv
`default_nettype none
// Attack ramp generator. Each input beat carries a gate bit and an attack length d in samples;
// each produces exactly one ramp beat, unsigned Q2.FRAC_BITS, that climbs 0, 1/d, 2/d, ...
// while the gate stays high and is 0 while it is low. A low gate passes from the idle state
// through the finishing state to the output. A rising gate edge runs a restoring division
// of 2^32 + d/2 by d, one quotient bit per cycle through the shared adder. A held gate runs a
// shift-and-add multiply of the sample count by the reciprocal on the same adder, one count
// bit per cycle up to the highest set bit of the count.
// The input is taken only while the sequencer is idle; a finished ramp waits in an output
// register, so the next beat may be accepted before the last one is taken.
module gate_to_attack_ramp import gtar_pkg::*; #(
  parameter int DUR_BITS  = 20,
  parameter int FRAC_BITS = 16
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire logic                    gate,
  input  wire logic [ATTACK_LEN_W-1:0] attack_len,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic      [FRAC_BITS+1:0]    ramp
);

  localparam int DW    = (DUR_BITS < ATTACK_LEN_W) ? DUR_BITS : ATTACK_LEN_W;
  localparam int PW    = DUR_BITS + RECIP_BITS;
  localparam int SHIFT = 32 - FRAC_BITS;
  localparam int RB    = FRAC_BITS + 2;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_MUL  = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;

  logic [1:0]            state;
  logic                  prev_gate;
  logic [DUR_BITS-1:0]   sample_count;
  logic [RECIP_BITS-1:0] recip_duration;
  logic [DW-1:0]         divisor;
  logic [DW-1:0]         rem;
  logic [RECIP_BITS-1:0] dq;
  logic [5:0]            step_cnt;
  logic [PW-1:0]         acc;
  logic [PW-1:0]         mcand;
  logic [DUR_BITS-1:0]   mplier;
  logic [RB-1:0]         res;

  logic                  accept;
  logic                  rise;
  logic [DW-1:0]         dsel;
  logic [DW-1:0]         d_in;
  logic [DW:0]           shifted;
  logic                  qbit;
  alu_op_t               alu_op;
  logic [PW-1:0]         alu_a;
  logic [PW-1:0]         alu_b;
  logic [PW-1:0]         alu_res;
  logic [RB-1:0]         ramp_sat;
  logic                  slot_free;

  assign in_ready  = (state == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign rise      = gate && !prev_gate;
  assign dsel      = attack_len[DW-1:0];
  assign d_in      = (dsel == '0) ? DW'(1) : dsel;
  assign shifted   = {rem, dq[RECIP_BITS-1]};
  assign slot_free = !out_valid || out_ready;

  always_comb begin
    if (state == ST_DIV) begin
      alu_op = ALU_SUB;
      alu_a  = {{(PW-DW-1){1'b0}}, shifted};
      alu_b  = {{(PW-DW){1'b0}}, divisor};
    end else begin
      alu_op = ALU_ADD;
      alu_a  = acc;
      alu_b  = mplier[0] ? mcand : '0;
    end
  end

  gtar_addsub #(
    .W (PW)
  ) u_addsub (
    .op     (alu_op),
    .a      (alu_a),
    .b      (alu_b),
    .result (alu_res)
  );

  // Both subtraction operands stay below half the adder range, so the top bit is the borrow.
  assign qbit = !alu_res[PW-1];

  always_comb begin
    if (alu_res[PW-1:SHIFT+RB] != '0) begin
      ramp_sat = '1;
    end else begin
      ramp_sat = alu_res[SHIFT+RB-1:SHIFT];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      prev_gate      <= 1'b0;
      sample_count   <= '0;
      recip_duration <= '0;
      out_valid      <= 1'b0;
    end else begin
      // In the finishing state a taken beat is replaced by the new one below.
      if (out_valid && out_ready && state != ST_FIN) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            prev_gate <= gate;
            if (!gate) begin
              sample_count <= '0;
            end else if (rise) begin
              sample_count <= DUR_BITS'(1);
            end else if (sample_count != '1) begin
              sample_count <= sample_count + DUR_BITS'(1);
            end
            if (!gate) begin
              res   <= '0;
              state <= ST_FIN;
            end else if (rise) begin
              divisor  <= d_in;
              rem      <= '0;
              dq       <= {1'b1, 32'(d_in >> 1)};
              step_cnt <= '0;
              state    <= ST_DIV;
            end else if (sample_count == '0) begin
              res   <= '0;
              state <= ST_FIN;
            end else begin
              acc    <= PW'(1) << (SHIFT - 1);
              mcand  <= PW'(recip_duration);
              mplier <= sample_count;
              state  <= ST_MUL;
            end
          end
        end
        ST_DIV: begin
          rem      <= qbit ? alu_res[DW-1:0] : shifted[DW-1:0];
          dq       <= {dq[RECIP_BITS-2:0], qbit};
          step_cnt <= step_cnt + 6'd1;
          if (step_cnt == 6'(RECIP_BITS - 1)) begin
            // The ramp of the rising sample uses a count of zero, so it is zero.
            recip_duration <= {dq[RECIP_BITS-2:0], qbit};
            res            <= '0;
            state          <= ST_FIN;
          end
        end
        ST_MUL: begin
          acc    <= alu_res;
          mcand  <= mcand << 1;
          mplier <= mplier >> 1;
          if (mplier[DUR_BITS-1:1] == '0) begin
            res   <= ramp_sat;
            state <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (slot_free) begin
            out_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FIN && slot_free) begin
      ramp <= res;
    end
  end

endmodule
`default_nettype wire

### dv/testbench.sv
`default_nettype none
module testbench;
  import gtar_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int DUR_BITS  = 20;
  localparam int FRAC_BITS = 16;
  localparam int RAMP_W    = FRAC_BITS + 2;
  localparam int PROD_SHIFT = 32 - FRAC_BITS;
  localparam logic [63:0] RAMP_MAX = (64'd1 << RAMP_W) - 64'd1;
  localparam logic [63:0] COUNT_MAX = (64'd1 << DUR_BITS) - 64'd1;
  localparam int RANDOM_ITEMS = 1100;
  localparam int TOTAL_ITEMS  = 1250;
  localparam int DRAIN_CYCLES = 50;

  logic                    clk;
  logic                    rst;
  logic                    in_valid;
  logic                    in_ready;
  logic                    gate;
  logic [ATTACK_LEN_W-1:0] attack_len;
  logic                    out_valid;
  logic                    out_ready;
  logic [RAMP_W-1:0]       ramp;

  gate_to_attack_ramp #(
    .DUR_BITS(DUR_BITS),
    .FRAC_BITS(FRAC_BITS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .gate(gate),
    .attack_len(attack_len),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .ramp(ramp)
  );

  // Envelope state as the block should hold it.
  logic                  env_prev_gate;
  logic [DUR_BITS-1:0]   env_count;
  logic [RECIP_BITS-1:0] env_recip;

  logic [RAMP_W-1:0] expected_ramp_q[$];
  logic [RAMP_W-1:0] wanted_ramp;
  int error_count;
  int samples_sent;
  int ramps_checked;
  int rise_count;
  int deepest_count;
  int saturated_ramps;
  bit in_idle_on;
  bit out_stall_on;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Advances the envelope by one sample and returns the ramp it should produce.
  function automatic logic [RAMP_W-1:0] predict_ramp(input logic g,
                                                     input logic [ATTACK_LEN_W-1:0] dur);
    logic        rise;
    logic [63:0] count_before;
    logic [63:0] divisor;
    logic [63:0] product;
    logic [63:0] rounded;
    rise = g && !env_prev_gate;
    count_before = 64'(env_count);
    if (rise) begin
      divisor = (dur == '0) ? 64'd1 : 64'(dur[DUR_BITS-1:0]);
      env_recip = RECIP_BITS'(((64'd1 << 32) + (divisor >> 1)) / divisor);
      rise_count++;
    end
    if (!g) begin
      env_count = '0;
    end else if (rise) begin
      env_count = DUR_BITS'(1);
    end else if (64'(env_count) < COUNT_MAX) begin
      env_count = env_count + DUR_BITS'(1);
    end
    env_prev_gate = g;
    if (int'(env_count) > deepest_count) begin
      deepest_count = int'(env_count);
    end
    if (!g) begin
      return '0;
    end
    product = count_before * 64'(env_recip);
    rounded = (product + (64'd1 << (PROD_SHIFT - 1))) >> PROD_SHIFT;
    if (rounded > RAMP_MAX) begin
      saturated_ramps++;
      return RAMP_W'(RAMP_MAX);
    end
    return RAMP_W'(rounded);
  endfunction

  // Entered and left on a falling edge.
  task automatic send_sample(input logic g, input logic [ATTACK_LEN_W-1:0] dur);
    if (in_idle_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end
    in_valid <= 1'b1;
    gate <= g;
    attack_len <= dur;
    do @(posedge clk); while (!in_ready);
    expected_ramp_q.push_back(predict_ramp(g, dur));
    samples_sent++;
    @(negedge clk);
  endtask

  // A rise, a hold of hold_len samples in total, then a release.
  task automatic play_envelope(input logic [ATTACK_LEN_W-1:0] dur, input int hold_len,
                               input int release_len);
    send_sample(1'b1, dur);
    for (int i = 1; i < hold_len; i++) send_sample(1'b1, ATTACK_LEN_W'($urandom));
    for (int i = 0; i < release_len; i++) send_sample(1'b0, ATTACK_LEN_W'($urandom));
  endtask

  function automatic logic [ATTACK_LEN_W-1:0] pick_duration();
    int sel;
    int msb;
    sel = $urandom_range(0, 99);
    msb = $urandom_range(0, ATTACK_LEN_W - 1);
    if (sel < 10) begin
      return '0;
    end else if (sel < 35) begin
      return ATTACK_LEN_W'($urandom_range(1, 16));
    end else if (sel < 65) begin
      return (ATTACK_LEN_W'(1) << msb) |
             (ATTACK_LEN_W'($urandom) & ((ATTACK_LEN_W'(1) << msb) - ATTACK_LEN_W'(1)));
    end
    return ATTACK_LEN_W'($urandom);
  endfunction

  // The ramp must stay at zero while the gate is low, whatever the duration.
  task automatic test_gate_low();
    send_sample(1'b0, '1);
    send_sample(1'b0, '0);
  endtask

  // A zero duration acts as one sample, so the ramp steps by 1.0 and saturates fast.
  task automatic test_zero_duration_saturation();
    play_envelope('0, 6, 1);
  endtask

  task automatic test_duration_extremes();
    play_envelope('1, 4, 1);
    play_envelope(ATTACK_LEN_W'(1), 3, 1);
    // Durations on the hold beats differ from the one latched at the rise.
    send_sample(1'b1, ATTACK_LEN_W'(3));
    send_sample(1'b1, ATTACK_LEN_W'(1));
    send_sample(1'b1, '0);
    send_sample(1'b1, '1);
    send_sample(1'b0, ATTACK_LEN_W'(3));
  endtask

  // Well-formed envelopes with random content, some cut short or run together.
  task automatic test_random_envelopes();
    int hold_len;
    int release_len;
    while (samples_sent < RANDOM_ITEMS) begin
      if (samples_sent == RANDOM_ITEMS / 3) begin
        in_idle_on = 1'b0;
        out_stall_on = 1'b0;
      end else if (samples_sent == RANDOM_ITEMS / 2) begin
        in_idle_on = 1'b1;
        out_stall_on = 1'b1;
      end
      if ($urandom_range(0, 9) == 0) begin
        send_sample(1'($urandom), ATTACK_LEN_W'($urandom));
      end else begin
        hold_len = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 40);
        release_len = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 4);
        play_envelope(pick_duration(), hold_len, release_len);
      end
    end
  endtask

  task automatic test_back_to_back();
    in_idle_on = 1'b0;
    out_stall_on = 1'b0;
    while (samples_sent < TOTAL_ITEMS) begin
      play_envelope(pick_duration(), $urandom_range(1, 30), $urandom_range(1, 3));
    end
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_ramp_q.size() == 0) begin
        $error("ramp beat 0x%05h with no sample waiting for it", ramp);
        error_count++;
      end else begin
        wanted_ramp = expected_ramp_q.pop_front();
        ramps_checked++;
        if (ramp !== wanted_ramp) begin
          $error("ramp: expected 0x%05h, got 0x%05h", wanted_ramp, ramp);
          error_count++;
        end
      end
    end
  end

  initial begin
    out_ready = 1'b0;
    @(negedge clk);
    forever begin
      if (out_stall_on && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(negedge clk);
      end
      out_ready <= 1'b1;
      @(negedge clk);
    end
  end

  initial begin
    int waited;
    rst = 1'b1;
    in_valid = 1'b0;
    gate = 1'b0;
    attack_len = '0;
    env_prev_gate = 1'b0;
    env_count = '0;
    env_recip = '0;
    error_count = 0;
    samples_sent = 0;
    ramps_checked = 0;
    rise_count = 0;
    deepest_count = 0;
    saturated_ramps = 0;
    in_idle_on = 1'b1;
    out_stall_on = 1'b1;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_gate_low();
    test_zero_duration_saturation();
    test_duration_extremes();
    test_random_envelopes();
    test_back_to_back();
    in_valid <= 1'b0;

    waited = 0;
    while (expected_ramp_q.size() != 0 && waited < 10000) begin
      @(posedge clk);
      waited++;
    end
    if (expected_ramp_q.size() != 0) begin
      $error("%0d ramp beats never arrived", expected_ramp_q.size());
      error_count++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d samples over %0d gate rises; checked %0d ramp beats.",
             samples_sent, rise_count, ramps_checked);
    $display("Longest hold reached count %0d; %0d ramps hit the saturation limit.",
             deepest_count, saturated_ramps);
    if (error_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("testbench: errors");
    $finish;
  end

endmodule
`default_nettype wire
